// File: src/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// shared types and constants of the priority schedule block
// ----------------------------------------------------------------------------
package pst_pkg;
    localparam int MaxProcs = 32;
    localparam int IdxW     = $clog2(MaxProcs);
    localparam int CntW     = $clog2(MaxProcs + 1);
    localparam int IdW      = 6;
    localparam int BurstW   = 16;
    localparam int PrioW    = 8;
    localparam int WaitW    = 21;
    localparam int TatW     = 22;
    // sums over all jobs, full precision
    localparam int SumW     = TatW + IdxW + 2;

    // one stored job, a single memory word
    typedef struct packed {
        logic [IdW-1:0]    id;
        logic [PrioW-1:0]  prio;
        logic [BurstW-1:0] burst;
    } t_job;

    // divider request and answer
    typedef struct packed {
        logic            start;
        logic [SumW-1:0] num_w;
        logic [SumW-1:0] num_t;
        logic [CntW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [SumW-1:0] q_w;
        logic [SumW-1:0] q_t;
    } t_div_rsp;
endpackage

// File: src/pst_div.sv
// ----------------------------------------------------------------------------
// pst_div
// restoring divider, one quotient bit per cycle, both averages side by side
// ----------------------------------------------------------------------------
module pst_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pst_pkg::t_div_req i_req,
    output pst_pkg::t_div_rsp o_rsp
);
    import pst_pkg::*;

    localparam int StepW = $clog2(SumW + 1);

    logic [SumW-1:0]  r_qw, r_qt, r_rw, r_rt;
    logic [CntW-1:0]  r_den;
    logic [StepW-1:0] r_step;
    logic             r_busy, r_done;
    logic [SumW:0]    n_rw, n_rt;

    always_comb begin
        n_rw = {r_rw, r_qw[SumW-1]};
        n_rt = {r_rt, r_qt[SumW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_qw   <= i_req.num_w;
                r_qt   <= i_req.num_t;
                r_rw   <= '0;
                r_rt   <= '0;
                r_den  <= i_req.den;
                r_step <= StepW'(SumW);
            end else if (r_busy) begin
                if (n_rw >= {{(SumW+1-CntW){1'b0}}, r_den}) begin
                    r_rw <= SumW'(n_rw - {{(SumW+1-CntW){1'b0}}, r_den});
                    r_qw <= {r_qw[SumW-2:0], 1'b1};
                end else begin
                    r_rw <= SumW'(n_rw);
                    r_qw <= {r_qw[SumW-2:0], 1'b0};
                end
                if (n_rt >= {{(SumW+1-CntW){1'b0}}, r_den}) begin
                    r_rt <= SumW'(n_rt - {{(SumW+1-CntW){1'b0}}, r_den});
                    r_qt <= {r_qt[SumW-2:0], 1'b1};
                end else begin
                    r_rt <= SumW'(n_rt);
                    r_qt <= {r_qt[SumW-2:0], 1'b0};
                end
                r_step <= r_step - 1'b1;
                if (r_step == StepW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q_w  = r_qw;
    assign o_rsp.q_t  = r_qt;
endmodule

// File: src/priority_schedule_times.sv
// ----------------------------------------------------------------------------
// priority_schedule_times
// non-preemptive priority scheduler: loads jobs, sorts by priority, emits times
// ----------------------------------------------------------------------------
// loading: one word per cycle until the word with tlast
// then selection sort, each compared entry read then compared and each pass closed
//   by a swap, then a sum pass, a divide and n result words, each one read and then
//   sent when the sink is ready
// the single read port of the job memory sets the sort length
// reset clears the job count, drop flag, output valid and state; memory holds no reset
module priority_schedule_times (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // burst_len[15:0], prio_level[23:16]
    input  logic        s_axis_tlast,   // is_final
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // job_id[5:0], job_burst[21:6], wait_time[42:22], turnaround[64:43],
    // avg_wait[85:65], avg_turnaround[107:86], zero fill [111:108]
    output logic [111:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // overflow_flag[0], run_end[1]
    output logic        m_axis_tlast    // run_end
);
    import pst_pkg::*;

    // sequencer states
    localparam logic [3:0] StLoad  = 4'd0;
    localparam logic [3:0] StSelRd = 4'd1;  // read candidate j
    localparam logic [3:0] StSelCk = 4'd2;  // compare candidate j
    localparam logic [3:0] StSwRdI = 4'd3;  // read entry i for swap
    localparam logic [3:0] StSwWrI = 4'd4;  // write min into i
    localparam logic [3:0] StSwWrP = 4'd5;  // write old i into pos
    localparam logic [3:0] StSumRd = 4'd6;
    localparam logic [3:0] StSumAc = 4'd7;
    localparam logic [3:0] StDiv   = 4'd8;
    localparam logic [3:0] StOutRd = 4'd9;
    localparam logic [3:0] StOut   = 4'd10;

    // job memory, one read and one write port
    t_job            mem [MaxProcs];
    t_job            r_rd;
    logic [IdxW-1:0] rd_addr, wr_addr;
    logic            wr_en;
    t_job            wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    logic [3:0]       r_st;
    logic [CntW-1:0]  r_cnt, r_i, r_j, r_pos;
    logic             r_drop;
    t_job             r_min, r_ji;
    logic [SumW-1:0]  r_acc, r_sw, r_st_sum;
    logic [WaitW-1:0] r_avw;
    logic [TatW-1:0]  r_avt;
    logic             r_ov, r_vld;
    logic             r_uov;     // overflow flag held with the result word
    logic [111:0]     r_data;
    logic             r_last;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    pst_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    assign s_axis_tready = (r_st == StLoad);

    logic acc_in;
    assign acc_in = s_axis_tvalid && s_axis_tready;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = IdxW'(r_cnt);
        wr_data = r_min;
        rd_addr = IdxW'(r_j);
        unique case (r_st)
            StLoad: begin
                wr_en   = acc_in && (r_cnt < CntW'(MaxProcs));
                wr_data = '{id: IdW'(r_cnt + 1'b1), prio: s_axis_tdata[23:16],
                            burst: s_axis_tdata[15:0]};
            end
            StSwRdI: rd_addr = IdxW'(r_i);
            StSwWrI: begin
                wr_en = 1'b1; wr_addr = IdxW'(r_i); wr_data = r_min;
            end
            StSwWrP: begin
                wr_en = 1'b1; wr_addr = IdxW'(r_pos); wr_data = r_ji;
            end
            StSumRd, StOutRd: rd_addr = IdxW'(r_i);
            default: ;
        endcase
    end

    always_comb begin
        div_req.start = (r_st == StSumAc) && (r_i + 1'b1 == r_cnt);
        div_req.num_w = r_sw + r_acc;
        div_req.num_t = r_st_sum + r_acc + SumW'(r_rd.burst);
        div_req.den   = r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= StLoad;
            r_cnt  <= '0;
            r_drop <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            if (r_vld && m_axis_tready) r_vld <= 1'b0;
            unique case (r_st)
                StLoad: if (acc_in) begin
                    if (r_cnt < CntW'(MaxProcs)) r_cnt <= r_cnt + 1'b1;
                    else r_drop <= 1'b1;
                    if (s_axis_tlast) begin
                        r_ov <= r_drop || (r_cnt == CntW'(MaxProcs));
                        r_i  <= '0;
                        r_j  <= '0;
                        r_pos <= '0;
                        r_st <= (r_cnt == '0 && r_cnt == CntW'(MaxProcs)) ? StLoad
                                                                         : StSelRd;
                    end
                end
                StSelRd: r_st <= StSelCk;
                StSelCk: begin
                    if (r_j == r_i || r_rd.prio < r_min.prio) begin
                        r_min <= r_rd;
                        r_pos <= r_j;
                    end
                    if (r_j + 1'b1 == r_cnt) r_st <= StSwRdI;
                    else begin
                        r_j  <= r_j + 1'b1;
                        r_st <= StSelRd;
                    end
                end
                StSwRdI: r_st <= StSwWrI;
                StSwWrI: begin
                    r_ji <= r_rd;
                    r_st <= StSwWrP;
                end
                StSwWrP: begin
                    if (r_i + 1'b1 == r_cnt) begin
                        r_i <= '0; r_acc <= '0; r_sw <= '0; r_st_sum <= '0;
                        r_st <= StSumRd;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_i + 1'b1;
                        r_st <= StSelRd;
                    end
                end
                StSumRd: r_st <= StSumAc;
                StSumAc: begin
                    r_sw     <= r_sw + r_acc;
                    r_st_sum <= r_st_sum + r_acc + SumW'(r_rd.burst);
                    r_acc    <= r_acc + SumW'(r_rd.burst);
                    if (r_i + 1'b1 == r_cnt) begin
                        r_st <= StDiv;
                    end else begin
                        r_i  <= r_i + 1'b1;
                        r_st <= StSumRd;
                    end
                end
                StDiv: if (div_rsp.done) begin
                    r_avw <= WaitW'(div_rsp.q_w);
                    r_avt <= TatW'(div_rsp.q_t);
                    r_i   <= '0;
                    r_acc <= '0;
                    r_st  <= StOutRd;
                end
                StOutRd: if (!r_vld || m_axis_tready) r_st <= StOut;
                StOut: begin
                    r_vld  <= 1'b1;
                    r_last <= (r_i + 1'b1 == r_cnt);
                    r_uov  <= r_ov;
                    r_data <= {4'b0, r_avt, r_avw,
                               TatW'(r_acc + SumW'(r_rd.burst)), WaitW'(r_acc),
                               r_rd.burst, r_rd.id};
                    r_acc  <= r_acc + SumW'(r_rd.burst);
                    if (r_i + 1'b1 == r_cnt) begin
                        r_cnt  <= '0;
                        r_drop <= 1'b0;
                        r_st   <= StLoad;
                    end else begin
                        r_i  <= r_i + 1'b1;
                        r_st <= StOutRd;
                    end
                end
                default: r_st <= StLoad;
            endcase
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = {r_last, r_uov};
    assign m_axis_tlast  = r_last;

    // a result word must never be overwritten before it is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !m_axis_tready |=> r_vld && $stable(r_data)) else $error("word lost");
    // the job count never exceeds the store depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(MaxProcs)) else $error("count overrun");
    // sort cursor stays inside the loaded jobs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == StSelCk) |-> (r_j < r_cnt) && (r_i <= r_j)) else $error("cursor");
endmodule

// File: tb/tb_priority_schedule_times.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_schedule_times
// self-checking bench: job sets are streamed in, a local scheduler predicts
// the order and times of every result word, which are checked as they leave
// ----------------------------------------------------------------------------

class sched_board;
    // predicted result words, oldest first
    logic [111:0] exp_data[$];
    logic [1:0]   exp_user[$];
    logic         exp_last[$];
    // jobs of the set being loaded
    logic [15:0]  set_burst[$];
    logic [7:0]   set_prio[$];
    logic [5:0]   set_id[$];
    bit           set_dropped;
    int           mismatches;

    // note an accepted input word; on the final word build the schedule
    function void note_job(logic [15:0] burst, logic [7:0] prio, logic fin);
        int n, pos;
        logic [15:0] tb;
        logic [7:0] tp;
        logic [5:0] ti;
        longint acc, sw, st, aw, at;
        longint waits[$];
        if (set_burst.size() < pst_pkg::MaxProcs) begin
            set_burst.push_back(burst);
            set_prio.push_back(prio);
            set_id.push_back(6'(set_burst.size()));
        end else begin
            set_dropped = 1;
        end
        if (!fin) return;
        n = set_burst.size();
        // selection sort with swaps, first strict minimum wins
        for (int i = 0; i < n; i++) begin
            pos = i;
            for (int j = i + 1; j < n; j++)
                if (set_prio[j] < set_prio[pos]) pos = j;
            tb = set_burst[i]; set_burst[i] = set_burst[pos]; set_burst[pos] = tb;
            tp = set_prio[i];  set_prio[i]  = set_prio[pos];  set_prio[pos]  = tp;
            ti = set_id[i];    set_id[i]    = set_id[pos];    set_id[pos]    = ti;
        end
        acc = 0; sw = 0; st = 0;
        for (int i = 0; i < n; i++) begin
            waits.push_back(acc);
            sw += acc;
            st += acc + set_burst[i];
            acc += set_burst[i];
        end
        aw = (n != 0) ? sw / n : 0;
        at = (n != 0) ? st / n : 0;
        for (int i = 0; i < n; i++) begin
            exp_data.push_back({4'b0, 22'(at), 21'(aw), 22'(waits[i] + set_burst[i]),
                                21'(waits[i]), set_burst[i], set_id[i]});
            exp_user.push_back({(i == n - 1), set_dropped});
            exp_last.push_back(i == n - 1);
        end
        set_burst.delete(); set_prio.delete(); set_id.delete();
        set_dropped = 0;
    endfunction

    function void check_word(logic [111:0] d, logic [1:0] u, logic l);
        if (exp_data.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", d);
            return;
        end
        if (d !== exp_data[0] || u !== exp_user[0] || l !== exp_last[0]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp data %h user %b last %b, got %h %b %b",
                         exp_data[0], exp_user[0], exp_last[0], d, u, l);
        end
        void'(exp_data.pop_front());
        void'(exp_user.pop_front());
        void'(exp_last.pop_front());
    endfunction
endclass

module tb_priority_schedule_times;
    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata;    // burst_len[15:0], prio_level[23:16]
    logic         s_axis_tlast;    // is_final
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;    // id, burst, wait, turnaround, averages
    logic [1:0]   m_axis_tuser;    // overflow_flag[0], run_end[1]
    logic         m_axis_tlast;

    sched_board board;
    int send_idle_pct;   // chance of a sender gap per cycle
    int recv_stall_pct;  // chance of a receiver stall per cycle

    priority_schedule_times dut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver: ready changes at the falling edge, words taken at the rising
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);

    // offer one job word and hold it until taken; valid drops only in a gap
    task automatic send_job(logic [15:0] burst, logic [7:0] prio, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {prio, burst};
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_job(burst, prio, fin);
        @(negedge i_clk);
    endtask

    // a set of n jobs; n above the store size exercises the drop path
    task automatic send_set(int n, int mode);
        logic [15:0] b;
        logic [7:0] p;
        for (int k = 0; k < n; k++) begin
            case (mode)
                0: begin b = 16'($urandom); p = 8'($urandom); end
                1: begin b = 16'hffff; p = 8'hff; end
                2: begin b = 16'h0; p = 8'h0; end
                default: begin b = 16'($urandom); p = 8'($urandom_range(3)); end
            endcase
            send_job(b, p, k == n - 1);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.exp_data.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        int n;
        board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tlast = 0;
        m_axis_tready = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: single job, extremes, ties, full store, overflow
        send_set(1, 0);
        send_set(1, 1);
        send_set(2, 2);
        send_set(3, 1);
        send_set(4, 3);
        send_set(8, 0);
        drain();   // sender holds off until all results are back
        send_set(32, 1);
        send_set(34, 0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int k = 0; k < 70; k += n) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(31, 36)
                                             : $urandom_range(1, 12);
                send_set(n, ($urandom_range(3) == 0) ? 3 : 0);
            end
        end
        drain();
        if (board.mismatches == 0 && board.exp_data.size() == 0)
            $display("** priority_schedule_times: PASSED **");
        else
            $display("** priority_schedule_times: FAILED **");
        $finish;
    end

    initial begin
        #40ms;
        $display("** priority_schedule_times: FAILED **");
        $finish;
    end
endmodule
